/* rtl/lkvc_pkg.sv */
// lkvc_pkg: shared types and constants for the lru key/value cache
// no dependencies
`timescale 1ns / 1ps
`default_nettype none
package lkvc_pkg;
  localparam int ENTRIES = 16;
  localparam int IDX_W = $clog2(ENTRIES);
  localparam int CNT_W = $clog2(ENTRIES + 1);
  localparam int CAP_W = 5;
  localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(16);
  localparam int KEY_W = 32;
  localparam int VAL_W = 32;

  localparam logic [1:0] ADDR_CAPACITY = 2'd0;

  localparam logic FUNC_GET = 1'b0;
  localparam logic FUNC_SET = 1'b1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_READ,
    ST_OUT
  } state_t;
endpackage
`default_nettype wire

/* rtl/lkvc_ram.sv */
// lkvc_ram: generic single-port-write ram with registered read
// no dependencies
`timescale 1ns / 1ps
`default_nettype none
module lkvc_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  // write port and registered read port
  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

/* rtl/lru_key_value_cache_top.sv */
// lru_key_value_cache_top: top level of the lru key/value cache
// uses lkvc_pkg and lkvc_ram (data memory)
`timescale 1ns / 1ps
`default_nettype none
// A fully associative store of ENTRIES key/value pairs with least recently
// used replacement. Keys, valid bits and age ranks live in flip-flops and are
// compared in parallel in the accept cycle; the data lives in a ram with a
// registered read. A request goes through accept and tag match, data read
// and result; new ones wait for idle. The capacity register (address 0)
// limits the entries in use; 0 acts as 1 and values above ENTRIES saturate.
module lru_key_value_cache_top
  import lkvc_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [63:0] s_tdata,  // key[31:0], value[63:32]
  input  wire logic        s_tuser,  // func
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic      [39:0] m_tdata,  // read_value[31:0], evicted[32], zero pad
  output logic             m_tuser,  // found
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic      [31:0] prdata,
  output logic             pready
);
  state_t state, state_next;
  logic [CAP_W-1:0] capacity;
  logic [ENTRIES-1:0] valid;
  logic [KEY_W-1:0] keys [ENTRIES];
  logic [IDX_W-1:0] age [ENTRIES];
  logic [CNT_W-1:0] used_count;
  logic found, evicted, is_get;
  logic [VAL_W-1:0] rdata;

  logic in_acc;
  assign in_acc = s_tvalid && s_tready;
  assign s_tready = (state == ST_IDLE);
  assign pready = 1'b1;
  assign prdata = {{(32-CAP_W){1'b0}}, capacity};

  // configuration write
  always_ff @(posedge clk) begin
    if (rst) capacity <= CAP_RESET;
    else if (psel && penable && pwrite && paddr[2] == 1'b0 && paddr[1:0] == ADDR_CAPACITY)
      capacity <= pwdata[CAP_W-1:0];
  end

  // parallel tag match, victim and free slot search
  logic [KEY_W-1:0] k;
  logic [VAL_W-1:0] v;
  logic hit, full;
  logic [IDX_W-1:0] hit_idx, vic_idx, free_idx, slot;
  logic [IDX_W-1:0] r;
  logic [CNT_W:0] effcap;
  assign k = s_tdata[31:0];
  assign v = s_tdata[63:32];
  always_comb begin
    hit = 1'b0; hit_idx = '0; vic_idx = '0; free_idx = '0;
    for (int i = ENTRIES-1; i >= 0; i--) begin
      if (valid[i] && keys[i] == k) begin hit = 1'b1; hit_idx = IDX_W'(i); end
      if (!valid[i]) free_idx = IDX_W'(i);
      if (valid[i] && age[i] == IDX_W'(used_count - 1'b1)) vic_idx = IDX_W'(i);
    end
    effcap = (capacity == '0) ? (CNT_W+1)'(1) :
             ((CNT_W+1)'(capacity) > (CNT_W+1)'(ENTRIES)) ? (CNT_W+1)'(ENTRIES) :
             (CNT_W+1)'(capacity);
    full = (CNT_W+1)'(used_count) >= effcap;
    slot = hit ? hit_idx : (full ? vic_idx : free_idx);
    r = age[slot];
  end

  logic do_touch, do_ins, do_write, data_we;
  assign do_touch = in_acc && (hit || (s_tuser == FUNC_SET && full && used_count != '0));
  assign do_ins = in_acc && s_tuser == FUNC_SET && !hit && !full;
  assign data_we = in_acc && s_tuser == FUNC_SET && (hit || do_touch || do_ins);
  assign do_write = in_acc && s_tuser == FUNC_SET && !hit;

  // tag, valid and age update
  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0; used_count <= '0;
      for (int i = 0; i < ENTRIES; i++) age[i] <= '0;
    end else begin
      if (do_touch) begin
        for (int i = 0; i < ENTRIES; i++)
          if (valid[i] && IDX_W'(i) != slot && age[i] < r) age[i] <= age[i] + 1'b1;
        age[slot] <= '0;
      end else if (do_ins) begin
        for (int i = 0; i < ENTRIES; i++)
          if (valid[i]) age[i] <= age[i] + 1'b1;
        age[slot] <= '0;
        valid[slot] <= 1'b1;
        used_count <= used_count + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_write && (do_touch || do_ins)) keys[slot] <= k;
  end

  // request result flags
  always_ff @(posedge clk) begin
    if (in_acc) begin
      found <= hit;
      is_get <= (s_tuser == FUNC_GET);
      evicted <= s_tuser == FUNC_SET && !hit && full && used_count != '0;
    end
  end

  // data memory
  lkvc_ram #(.WIDTH(VAL_W), .DEPTH(ENTRIES)) u_data (
    .clk(clk), .we(data_we), .waddr(slot), .wdata(v), .raddr(slot), .rdata(rdata)
  );

  logic [VAL_W-1:0] out_val;
  always_ff @(posedge clk) begin
    if (state == ST_READ) out_val <= (is_get && found) ? rdata : '0;
  end

  // sequencer next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: if (in_acc) state_next = ST_READ;
      ST_READ: state_next = ST_OUT;
      ST_OUT:  if (m_tready) state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= ST_IDLE;
    else state <= state_next;
  end

  // outputs
  always_comb begin
    m_tvalid = (state == ST_OUT);
    m_tdata = {7'b0, evicted, out_val};
    m_tuser = found;
  end
endmodule
`default_nettype wire
